/* rtl/mmu_pkg.sv */
package mmu_pkg;

  localparam int MMU_MAX_DIM    = 8;
  localparam int MMU_ELEM_WIDTH = 16;

  // configuration register field width and index width
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 32;
  localparam int IDX_OUT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              req_type;
    logic signed [15:0] elem_value;
  } mmu_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]   prod_value;
    logic [IDX_OUT_W-1:0]      out_row;
    logic [IDX_OUT_W-1:0]      out_col;
    logic                      is_last;
  } mmu_out_t;

  // controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
    logic load_out;
  } mac_ctrl_t;

endpackage

/* rtl/mmu_store.sv */
module mmu_store import mmu_pkg::*; #(
  parameter int DEPTH = MMU_MAX_DIM * MMU_MAX_DIM,
  parameter int WIDTH = MMU_ELEM_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/mmu_mac.sv */
module mmu_mac import mmu_pkg::*; #(
  parameter int SW    = 16,
  parameter int ACC_W = 2 * SW + 4
) (
  input  logic                    clk,
  input  mac_ctrl_t               ctrl,
  input  logic signed [SW-1:0]    a_in,
  input  logic signed [SW-1:0]    b_in,
  output logic signed [OUT_W-1:0] res_r
);

  localparam int SAT_W = (ACC_W > OUT_W + 1) ? ACC_W : OUT_W + 1;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(64'shffff_ffff_8000_0000);

  logic signed [2*SW-1:0]  prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SAT_W-1:0] acc_ext;
  logic signed [OUT_W-1:0] sat_val;

  // product register, then accumulate
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= (2*SW)'(a_in) * (2*SW)'(b_in);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc_ext = SAT_W'(acc_r);

  always_comb begin
    if (acc_ext > SAT_MAX) begin
      sat_val = SAT_MAX[OUT_W-1:0];
    end else if (acc_ext < SAT_MIN) begin
      sat_val = SAT_MIN[OUT_W-1:0];
    end else begin
      sat_val = acc_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      res_r <= sat_val;
    end
  end

endmodule

/* rtl/matrix_matrix_multiply_unit.sv */
// matrix product unit, C = A * B, signed Q8.8 in, saturated signed Q16.16 out
//
// input channel: an element beat is taken on a clock edge with start high
// and busy low; in_data.req_type picks A (0) or B (1), elements arrive in
// row-major order, and an element for a matrix that is already full is dropped
// config channel: cfg_valid/cfg_ready write rows_a (0), inner_dim (1) and
// cols_b (2); 0 acts as 1 and values above MAX_DIM act as MAX_DIM
// result channel: out_valid strobes one cycle per beat, rows then columns,
// with out_data.is_last on the final element; the receiver cannot stall
//
// loading takes one cycle per element. on the beat that fills both matrices
// busy rises and one shared multiply-accumulate unit walks the products:
// each result element is summed from one store read of A(i,k) and B(k,j) per
// cycle, each product passing the store read, the product register and the
// accumulator; the next element is issued only after the last product has
// landed, and the result is registered together with its out_valid strobe
// reset clears the element counters and sets all sizes to 8; store contents
// are not cleared and are only read where they were written
module matrix_matrix_multiply_unit import mmu_pkg::*; #(
  parameter int MAX_DIM    = MMU_MAX_DIM,
  parameter int ELEM_WIDTH = MMU_ELEM_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mmu_in_t              in_data,
  output logic                 out_valid,
  output mmu_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // stored element width: narrow builds keep only the low bits
  localparam int SW    = (ELEM_WIDTH < 16) ? ELEM_WIDTH : 16;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ACC_W = 2 * SW + $clog2(MAX_DIM) + 1;
  localparam int SZ_W  = 2 * CFG_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // size registers as written
  logic [CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;

  // effective sizes and sizes latched for the compute pass
  logic [CFG_W-1:0] m_eff, n_eff, p_eff;
  logic [CFG_W-1:0] m_r, m_nxt, n_r, n_nxt, p_r, p_nxt;
  logic [SZ_W-1:0]  size_a, size_b;

  logic [CNT_W-1:0] count_a_r, count_a_nxt, count_b_r, count_b_nxt;

  // loop counters and store addresses
  logic [CFG_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0]    a_row_r, a_row_nxt, a_idx_r, a_idx_nxt, b_idx_r, b_idx_nxt;

  // read and multiply pipeline valids
  logic rd_vld_r, rd_vld_nxt, mul_vld_r, mul_vld_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0] out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic                 is_last_r, is_last_nxt;

  logic          accept, wr_a, wr_b, both_full;
  logic [SW-1:0] elem;
  logic [SW-1:0] a_data, b_data;
  mac_ctrl_t     mac_ctrl;
  logic signed [OUT_W-1:0] res;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] v;
    if (r == '0) begin
      v = CFG_W'(1);
    end else if (r > CFG_W'(MAX_DIM)) begin
      v = CFG_W'(MAX_DIM);
    end else begin
      v = r;
    end
    return v;
  endfunction

  assign m_eff  = eff_dim(rows_a_r);
  assign n_eff  = eff_dim(inner_dim_r);
  assign p_eff  = eff_dim(cols_b_r);
  assign size_a = SZ_W'(m_eff) * SZ_W'(n_eff);
  assign size_b = SZ_W'(n_eff) * SZ_W'(p_eff);

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = start && !busy;
  assign elem      = in_data.elem_value[SW-1:0];

  // element stored only while its matrix has room
  assign wr_a = accept && !in_data.req_type && (SZ_W'(count_a_r) < size_a)
                && (count_a_r < CNT_W'(DEPTH));
  assign wr_b = accept && in_data.req_type && (SZ_W'(count_b_r) < size_b)
                && (count_b_r < CNT_W'(DEPTH));
  // counts after this beat's element has been stored
  assign both_full = ((SZ_W'(count_a_r) + SZ_W'(wr_a)) >= size_a)
                     && ((SZ_W'(count_b_r) + SZ_W'(wr_b)) >= size_b);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_W'(8);
      inner_dim_r <= CFG_W'(8);
      cols_b_r    <= CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_data;
        CFG_INNER_DIM: inner_dim_r <= cfg_data;
        CFG_COLS_B:    cols_b_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    a_row_nxt     = a_row_r;
    a_idx_nxt     = a_idx_r;
    b_idx_nxt     = b_idx_r;
    rd_vld_nxt    = 1'b0;
    mul_vld_nxt   = rd_vld_r;
    out_valid_nxt = 1'b0;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    is_last_nxt   = is_last_r;
    mac_ctrl      = '{clr: 1'b0, mul_en: rd_vld_r, acc_en: mul_vld_r, load_out: 1'b0};

    if (wr_a) begin
      count_a_nxt = count_a_r + 1'b1;
    end
    if (wr_b) begin
      count_b_nxt = count_b_r + 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && both_full) begin
          // both matrices complete: start the product pass
          state_nxt    = S_ISSUE;
          m_nxt        = m_eff;
          n_nxt        = n_eff;
          p_nxt        = p_eff;
          i_nxt        = '0;
          j_nxt        = '0;
          k_nxt        = '0;
          a_row_nxt    = '0;
          a_idx_nxt    = '0;
          b_idx_nxt    = '0;
          mac_ctrl.clr = 1'b1;
        end
      end
      S_ISSUE: begin
        // one read of A(i,k) and B(k,j) per cycle
        rd_vld_nxt = 1'b1;
        a_idx_nxt  = a_idx_r + 1'b1;
        b_idx_nxt  = b_idx_r + AW'(p_r);
        k_nxt      = k_r + 1'b1;
        if (k_r == n_r - 1'b1) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!rd_vld_r && !mul_vld_r) begin
          out_valid_nxt     = 1'b1;
          out_row_nxt       = IDX_OUT_W'(i_r);
          out_col_nxt       = IDX_OUT_W'(j_r);
          is_last_nxt       = (i_r == m_r - 1'b1) && (j_r == p_r - 1'b1);
          mac_ctrl.load_out = 1'b1;
          mac_ctrl.clr      = 1'b1;
          state_nxt         = S_ISSUE;
          if (j_r == p_r - 1'b1) begin
            // next row of the result
            j_nxt     = '0;
            i_nxt     = i_r + 1'b1;
            a_row_nxt = a_row_r + AW'(n_r);
            a_idx_nxt = a_row_r + AW'(n_r);
            b_idx_nxt = '0;
            if (i_r == m_r - 1'b1) begin
              state_nxt   = S_IDLE;
              count_a_nxt = '0;
              count_b_nxt = '0;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            a_idx_nxt = a_row_r;
            b_idx_nxt = AW'(j_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      rd_vld_r    <= rd_vld_nxt;
      mul_vld_r   <= mul_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    n_r       <= n_nxt;
    p_r       <= p_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    a_row_r   <= a_row_nxt;
    a_idx_r   <= a_idx_nxt;
    b_idx_r   <= b_idx_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    is_last_r <= is_last_nxt;
  end

  mmu_store #(
    .DEPTH (DEPTH),
    .WIDTH (SW),
    .AW    (AW)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a_r[AW-1:0]),
    .wr_data (elem),
    .rd_addr (a_idx_r),
    .rd_data (a_data)
  );

  mmu_store #(
    .DEPTH (DEPTH),
    .WIDTH (SW),
    .AW    (AW)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b_r[AW-1:0]),
    .wr_data (elem),
    .rd_addr (b_idx_r),
    .rd_data (b_data)
  );

  mmu_mac #(
    .SW    (SW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .a_in  (a_data),
    .b_in  (b_data),
    .res_r (res)
  );

  assign out_valid           = out_valid_r;
  assign out_data.prod_value = res;
  assign out_data.out_row    = out_row_r;
  assign out_data.out_col    = out_col_r;
  assign out_data.is_last    = is_last_r;

  // a result beat only follows a finished accumulation
  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DRAIN))
    else $error("result beat without a finished accumulation");

  // the final beat leaves the unit ready for loading
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && is_last_r) |-> (state_r == S_IDLE && count_a_r == '0 && count_b_r == '0))
    else $error("last beat while product pass still running");

  // store reads are only issued by the issue step
  a_read_in_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_ISSUE))
    else $error("store read outside the issue step");

  // element counters never pass the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CNT_W'(DEPTH)) && (count_b_r <= CNT_W'(DEPTH)))
    else $error("element counter past store depth");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mmu_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n;

  // element channel
  logic     start;
  logic     busy;
  mmu_in_t  in_data;

  // result channel, no back-pressure possible
  logic     out_valid;
  mmu_out_t out_data;

  // register write channel
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  matrix_matrix_multiply_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // element beats waiting to be driven, product elements waiting to arrive
  mmu_in_t  element_queue[$];
  mmu_out_t expected_c[$];

  // shadow copy of the block: register values, element stores and counters
  logic [CFG_W-1:0]   rows_cfg;
  logic [CFG_W-1:0]   inner_cfg;
  logic [CFG_W-1:0]   cols_cfg;
  logic signed [15:0] a_store [MMU_MAX_DIM*MMU_MAX_DIM];
  logic signed [15:0] b_store [MMU_MAX_DIM*MMU_MAX_DIM];
  int                 cnt_a;
  int                 cnt_b;

  // percentage chance that the driver holds start low instead of presenting a waiting beat
  int idle_pct;
  int idle_sched[4] = '{0, 88, 0, 18};

  // run statistics
  int n_errors;
  int n_accepted;
  int n_checked;
  int n_products;
  int n_cfg_writes;
  int n_random;

  // a size register of 0 behaves as 1, anything above the maximum as the maximum
  function automatic int clamp_dim(input logic [CFG_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MMU_MAX_DIM) return MMU_MAX_DIM;
    return int'(r);
  endfunction

  // store or drop one element beat; once both matrices are complete, work out
  // all of C = A * B, exact sums clamped to signed 32 bits, and queue it
  task automatic take_element(input mmu_in_t beat);
    int       m;
    int       n;
    int       p;
    int       i;
    int       j;
    int       k;
    longint   acc;
    mmu_out_t r;
    m = clamp_dim(rows_cfg);
    n = clamp_dim(inner_cfg);
    p = clamp_dim(cols_cfg);
    // sizes are taken afresh on every beat, so a shrink can make a matrix full
    if (beat.req_type == 1'b0) begin
      if (cnt_a < m * n) begin
        a_store[cnt_a] = beat.elem_value;
        cnt_a++;
      end
    end else begin
      if (cnt_b < n * p) begin
        b_store[cnt_b] = beat.elem_value;
        cnt_b++;
      end
    end
    if (cnt_a >= m * n && cnt_b >= n * p) begin
      for (i = 0; i < m; i++) begin
        for (j = 0; j < p; j++) begin
          acc = 0;
          for (k = 0; k < n; k++) begin
            acc += longint'(a_store[i*n+k]) * longint'(b_store[k*p+j]);
          end
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          r.prod_value = acc[31:0];
          r.out_row    = 3'(i);
          r.out_col    = 3'(j);
          r.is_last    = (i == m - 1 && j == p - 1);
          expected_c.push_back(r);
        end
      end
      cnt_a = 0;
      cnt_b = 0;
      n_products++;
    end
  endtask

  // driver: start is held through busy, the accepted beat goes to the shadow
  // model, and the next beat is either presented or replaced by an idle cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        take_element(in_data);
        n_accepted++;
      end
      if (element_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        in_data <= element_queue.pop_front();
      end else begin
        start   <= 1'b0;
      end
    end
  end

  // monitor: every strobed result is matched against the oldest expected one
  always @(posedge clk) begin
    mmu_out_t want;
    if (rst_n && out_valid) begin
      if (expected_c.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d row %0d col %0d last %0b",
                 $time, $signed(out_data.prod_value), out_data.out_row,
                 out_data.out_col, out_data.is_last);
        n_errors++;
      end else begin
        want = expected_c.pop_front();
        n_checked++;
        if (out_data.prod_value !== want.prod_value) begin
          $display("%0t: prod_value mismatch, expected %0d, got %0d", $time,
                   $signed(want.prod_value), $signed(out_data.prod_value));
          n_errors++;
        end
        if (out_data.out_row !== want.out_row) begin
          $display("%0t: out_row mismatch, expected %0d, got %0d", $time,
                   want.out_row, out_data.out_row);
          n_errors++;
        end
        if (out_data.out_col !== want.out_col) begin
          $display("%0t: out_col mismatch, expected %0d, got %0d", $time,
                   want.out_col, out_data.out_col);
          n_errors++;
        end
        if (out_data.is_last !== want.is_last) begin
          $display("%0t: is_last mismatch, expected %0b, got %0b", $time,
                   want.is_last, out_data.is_last);
          n_errors++;
        end
      end
    end
  end

  // one register write beat; the shadow copy follows on the accepting edge
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROWS_A:    rows_cfg = val;
      CFG_INNER_DIM: inner_cfg = val;
      CFG_COLS_B:    cols_cfg = val;
      default: ;  // unused index, write has no effect
    endcase
    n_cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // all beats taken, all results in, block quiet, then a margin for latency
  task automatic wait_idle();
    do @(negedge clk);
    while (element_queue.size() != 0 || start || busy || expected_c.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic push_elem(input logic is_b, input logic [15:0] v);
    element_queue.push_back(mmu_in_t'{req_type: is_b, elem_value: v});
  endtask

  // biased toward the extremes so that saturation shows up often
  function automatic logic [15:0] rand_elem();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return {{6{r[9]}}, r[9:0]};
      default: return r[15:0];
    endcase
  endfunction

  // mostly small sizes, sometimes large, sometimes out of range
  function automatic logic [CFG_W-1:0] rand_dim();
    case ($urandom_range(19))
      0: return '0;
      1: return 4'($urandom_range(15, 9));
      2, 3: return 4'($urandom_range(8, 5));
      default: return 4'($urandom_range(4, 1));
    endcase
  endfunction

  // one load of A and B for the current sizes, the two matrices interleaved
  // at random; now and then an element for a full matrix (dropped), and a cut
  // load leaves the counters partly filled for the next register change
  task automatic queue_load(input bit cut_short, output int n_items);
    int na;
    int nb;
    int ia;
    int ib;
    int limit;
    bit pick_b;
    na = clamp_dim(rows_cfg) * clamp_dim(inner_cfg);
    nb = clamp_dim(inner_cfg) * clamp_dim(cols_cfg);
    limit = cut_short ? $urandom_range(na + nb - 1, 1) : na + nb;
    ia = 0;
    ib = 0;
    n_items = 0;
    while ((ia < na || ib < nb) && n_items < limit) begin
      pick_b = (ia == na) || (ib < nb && $urandom_range(1) == 1);
      push_elem(pick_b, rand_elem());
      if (pick_b) ib++;
      else ia++;
      n_items++;
      // extra element for the matrix that is already complete
      if ((ia == na) != (ib == nb) && $urandom_range(19) == 0) begin
        push_elem(ia == na ? 1'b0 : 1'b1, rand_elem());
      end
    end
  endtask

  // stimulus
  initial begin
    int phase;
    int n_loads;
    int got;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROWS_A;
    cfg_data  = '0;
    idle_pct  = 0;
    n_errors     = 0;
    n_accepted   = 0;
    n_checked    = 0;
    n_products   = 0;
    n_cfg_writes = 0;
    n_random     = 0;
    rows_cfg  = 4'd8;
    inner_cfg = 4'd8;
    cols_cfg  = 4'd8;
    cnt_a = 0;
    cnt_b = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // zero rows acts as one row; two most-negative products saturate high,
    // and a third A element arrives after A is full and is dropped
    write_reg(CFG_ROWS_A, 4'd0);
    write_reg(CFG_INNER_DIM, 4'd2);
    write_reg(CFG_COLS_B, 4'd1);
    @(negedge clk);
    push_elem(1'b0, 16'h8000);
    push_elem(1'b0, 16'h8000);
    push_elem(1'b0, 16'h0123);
    push_elem(1'b1, 16'h8000);
    push_elem(1'b1, 16'h8000);
    wait_idle();

    // write to the unused index changes nothing; 1x3 by 3x1 saturates low
    write_reg(CFG_UNUSED, 4'hF);
    write_reg(CFG_ROWS_A, 4'd1);
    write_reg(CFG_INNER_DIM, 4'd3);
    @(negedge clk);
    push_elem(1'b1, 16'h7FFF);
    push_elem(1'b0, 16'h8000);
    push_elem(1'b0, 16'h8000);
    push_elem(1'b1, 16'h7FFF);
    push_elem(1'b0, 16'h8000);
    push_elem(1'b1, 16'h7FFF);
    wait_idle();

    // single product of the two most negative values, B arriving first
    write_reg(CFG_INNER_DIM, 4'd1);
    @(negedge clk);
    push_elem(1'b1, 16'h8000);
    push_elem(1'b0, 16'h8000);
    wait_idle();

    // rows shrink while A is half loaded: A counts as full, and the next beat
    // (an A element, dropped) sets off the product
    write_reg(CFG_ROWS_A, 4'd2);
    write_reg(CFG_COLS_B, 4'd2);
    @(negedge clk);
    push_elem(1'b0, 16'h0100);
    push_elem(1'b1, 16'hFFFF);
    push_elem(1'b1, 16'h0000);
    wait_idle();
    write_reg(CFG_ROWS_A, 4'd1);
    @(negedge clk);
    push_elem(1'b0, 16'h7FFF);
    wait_idle();

    // random phases, each with its own sizes and idle pattern
    phase = 0;
    while (n_random < 430) begin
      idle_pct = idle_sched[phase % 4];
      if (phase == 0) begin
        // 8x1 by 1x8: every row and column index, rows through an
        // out-of-range value
        write_reg(CFG_ROWS_A, 4'd15);
        write_reg(CFG_INNER_DIM, 4'd1);
        write_reg(CFG_COLS_B, 4'd8);
      end else if (phase == 1) begin
        // the full-size product, once
        write_reg(CFG_ROWS_A, 4'd8);
        write_reg(CFG_INNER_DIM, 4'd8);
        write_reg(CFG_COLS_B, 4'd8);
      end else begin
        if ($urandom_range(3) != 0) write_reg(CFG_ROWS_A, rand_dim());
        if ($urandom_range(3) != 0) write_reg(CFG_INNER_DIM, rand_dim());
        if ($urandom_range(3) != 0) write_reg(CFG_COLS_B, rand_dim());
        if ($urandom_range(5) == 0) write_reg(CFG_UNUSED, 4'($urandom));
      end
      @(negedge clk);
      n_loads = (phase < 2) ? 1 : $urandom_range(4, 1);
      for (int l = 0; l < n_loads; l++) begin
        queue_load(phase >= 2 && l == n_loads - 1 && $urandom_range(7) == 0, got);
        n_random += got;
      end
      wait_idle();
      phase++;
    end

    // the margin in wait_idle covers the latency after the last result
    wait_idle();
    $display("%0d element beats taken, %0d matrix products, %0d result elements checked",
             n_accepted, n_products, n_checked);
    $display("%0d register writes over %0d random phases, %0d mismatches",
             n_cfg_writes, phase, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", expected_c.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
